>>> src/vpf_pkg.sv
package vpf_pkg;

  localparam int COORD_W    = 12;
  localparam int RADIUS_W   = 16;
  localparam int MAT_W      = 8;
  localparam int CMD_W      = 3;
  localparam int SIZE_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int FRAC_SHIFT = 8;
  localparam int CMP_W      = SUM_W + FRAC_SHIFT;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
  localparam logic [MAT_W-1:0]  MAT_CLEAR  = 8'd0;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOB  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET      = 3'd0,
    CMD_UNIFORM  = 3'd1,
    CMD_BOX      = 3'd2,
    CMD_SPHERE   = 3'd3,
    CMD_CYLINDER = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ADDR_ROW,
    ST_ADDR_BASE,
    ST_SINGLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] x_a;
    logic signed [COORD_W-1:0] x_b;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] y_b;
    logic signed [COORD_W-1:0] z_a;
    logic signed [COORD_W-1:0] z_b;
    logic [RADIUS_W-1:0]       radius;
    logic [MAT_W-1:0]          material;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [MAT_W-1:0] read_material;
  } rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_c;
    logic signed [COORD_W-1:0] y_c;
    logic signed [COORD_W-1:0] z_c;
    logic [RADIUS_W-1:0]       radius;
    logic                      use_dz;
  } dist_cfg_t;

endpackage

>>> src/voxel_primitive_fill.sv
// Channel   Direction  Payload              Handshake
// req       in         req_t command        req_valid / req_ready
// rsp       out        rsp_t result         rsp_valid / rsp_ready
// cfg       in         cfg_index, cfg_data  cfg_valid / cfg_ready (always ready)
//
// After reset a clearing pass writes zero to every voxel; no request is taken during it,
// while configuration writes are taken throughout. An in-range set or read goes from
// acceptance through setup, two address states and a single access to the finish state.
// A non-empty fill goes through setup and the address states, then sweeps its range one
// voxel a cycle for the single memory write port and drains the distance pipeline.
// A stalled result waits in the output register while the next request is accepted.
module voxel_primitive_fill
  import vpf_pkg::*;
#(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int MAX_XY     = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
  localparam int MAX_ALL    = (MAX_XY > MAX_Z) ? MAX_XY : MAX_Z;
  localparam int CW         = $clog2(MAX_ALL + 1);
  localparam int DEPTH      = MAX_X * MAX_Y * MAX_Z;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_STEP   = MAX_Z;
  localparam int PLANE_STEP = MAX_Y * MAX_Z;

  function automatic logic [CW-1:0] ext_in_use(input logic [SIZE_W-1:0] r,
                                               input int maxv);
    if (int'(r) > maxv) begin
      return CW'(maxv);
    end
    return CW'(r);
  endfunction

  function automatic logic [CW-1:0] clamp_range(input logic signed [COORD_W-1:0] v,
                                                input logic [CW-1:0] e);
    logic signed [COORD_W:0] vs;
    logic signed [COORD_W:0] es;
    vs = {v[COORD_W-1], v};
    es = signed'({{(COORD_W+1-CW){1'b0}}, e});
    if (vs < 0) begin
      return '0;
    end
    if (vs > es) begin
      return e;
    end
    return CW'(v);
  endfunction

  function automatic logic in_range(input logic signed [COORD_W-1:0] v,
                                    input logic [CW-1:0] e);
    logic signed [COORD_W:0] vs;
    logic signed [COORD_W:0] es;
    vs = {v[COORD_W-1], v};
    es = signed'({{(COORD_W+1-CW){1'b0}}, e});
    return (vs >= 0) && (vs < es);
  endfunction

  state_t state, state_next;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [CW-1:0]     ex, ey, ez;

  req_t              req_q;
  logic [CW-1:0]     lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic              single, sweep, oob, use_dist, use_dz, empty;

  logic [CW-1:0]     cnt_x, cnt_y, cnt_z;
  logic [CW-1:0]     xhi, yhi, zhi, ylo, zlo;
  logic              single_q, use_dist_q, use_dz_q, status_q;
  logic [AW-1:0]     p_q, row, plane, clr_addr;
  logic              z_last, y_last, x_last, sweep_done;

  logic              sweep_issue, rsp_load;
  logic              s1_valid, s2_valid;
  logic [AW-1:0]     s1_addr, s2_addr;
  logic              hit;
  dist_cfg_t         dcfg;

  logic [MAT_W-1:0]  mem [DEPTH];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [MAT_W-1:0]  mem_wdata, rd_q;
  logic              is_read;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ex = ext_in_use(size_x, MAX_X);
  assign ey = ext_in_use(size_y, MAX_Y);
  assign ez = ext_in_use(size_z, MAX_Z);

  assign is_read = (req_q.command == CMD_READ);

  always_comb begin
    lo_x     = '0;
    lo_y     = '0;
    lo_z     = '0;
    hi_x     = ex;
    hi_y     = ey;
    hi_z     = ez;
    single   = 1'b0;
    sweep    = 1'b0;
    oob      = 1'b0;
    use_dist = 1'b0;
    use_dz   = 1'b0;
    unique case (req_q.command)
      CMD_SET, CMD_READ: begin
        if (in_range(req_q.x_a, ex) && in_range(req_q.y_a, ey) &&
            in_range(req_q.z_a, ez)) begin
          lo_x   = CW'(req_q.x_a);
          lo_y   = CW'(req_q.y_a);
          lo_z   = CW'(req_q.z_a);
          single = 1'b1;
        end else begin
          oob = 1'b1;
        end
      end
      CMD_UNIFORM: sweep = 1'b1;
      CMD_BOX: begin
        lo_x  = clamp_range(req_q.x_a, ex);
        hi_x  = clamp_range(req_q.x_b, ex);
        lo_y  = clamp_range(req_q.y_a, ey);
        hi_y  = clamp_range(req_q.y_b, ey);
        lo_z  = clamp_range(req_q.z_a, ez);
        hi_z  = clamp_range(req_q.z_b, ez);
        sweep = 1'b1;
      end
      CMD_SPHERE: begin
        sweep    = 1'b1;
        use_dist = 1'b1;
        use_dz   = 1'b1;
      end
      CMD_CYLINDER: begin
        lo_z     = clamp_range(req_q.z_a, ez);
        hi_z     = clamp_range(req_q.z_b, ez);
        sweep    = 1'b1;
        use_dist = 1'b1;
      end
      default: ;
    endcase
    empty = (lo_x >= hi_x) || (lo_y >= hi_y) || (lo_z >= hi_z);
  end

  assign z_last     = ((cnt_z + CW'(1)) == zhi);
  assign y_last     = ((cnt_y + CW'(1)) == yhi);
  assign x_last     = ((cnt_x + CW'(1)) == xhi);
  assign sweep_done = z_last && y_last && x_last;

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    sweep_issue = 1'b0;
    rsp_load    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (single || (sweep && !empty)) begin
          state_next = ST_ADDR_ROW;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ADDR_ROW:  state_next = ST_ADDR_BASE;
      ST_ADDR_BASE: state_next = single_q ? ST_SINGLE : ST_SWEEP;
      ST_SINGLE:    state_next = ST_FINISH;
      ST_SWEEP: begin
        sweep_issue = 1'b1;
        if (sweep_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    unique case (state)
      ST_SETUP: begin
        cnt_x      <= lo_x;
        cnt_y      <= lo_y;
        cnt_z      <= lo_z;
        ylo        <= lo_y;
        zlo        <= lo_z;
        xhi        <= hi_x;
        yhi        <= hi_y;
        zhi        <= hi_z;
        single_q   <= single;
        use_dist_q <= use_dist;
        use_dz_q   <= use_dz;
        status_q   <= oob ? STATUS_OOB : STATUS_DONE;
      end
      ST_ADDR_ROW: begin
        p_q <= AW'(32'(cnt_x) * 32'(MAX_Y) + 32'(cnt_y));
      end
      ST_ADDR_BASE: begin
        row   <= AW'(32'(p_q) * 32'(MAX_Z));
        plane <= AW'(32'(p_q) * 32'(MAX_Z));
      end
      ST_SWEEP: begin
        if (z_last) begin
          cnt_z <= zlo;
          if (y_last) begin
            cnt_y <= ylo;
            cnt_x <= cnt_x + CW'(1);
            plane <= plane + AW'(PLANE_STEP);
            row   <= plane + AW'(PLANE_STEP);
          end else begin
            cnt_y <= cnt_y + CW'(1);
            row   <= row + AW'(ROW_STEP);
          end
        end else begin
          cnt_z <= cnt_z + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= sweep_issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= row + AW'(cnt_z);
    s2_addr <= s1_addr;
  end

  assign dcfg = '{x_c: req_q.x_a, y_c: req_q.y_a, z_c: req_q.z_a,
                  radius: req_q.radius, use_dz: use_dz_q};

  vpf_dist #(
    .CW(CW)
  ) u_dist (
    .clk (clk),
    .cfg (dcfg),
    .x   (cnt_x),
    .y   (cnt_y),
    .z   (cnt_z),
    .hit (hit)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s2_addr;
    mem_wdata = req_q.material;
    priority if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = MAT_CLEAR;
    end else if (state == ST_SINGLE && req_q.command == CMD_SET) begin
      mem_we    = 1'b1;
      mem_waddr = row + AW'(cnt_z);
    end else if (s2_valid && (!use_dist_q || hit)) begin
      mem_we = 1'b1;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_re    = (state == ST_SINGLE) && is_read;
  assign mem_raddr = row + AW'(cnt_z);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status        <= status_q;
      rsp.read_material <= (is_read && status_q == STATUS_DONE) ? rd_q : MAT_CLEAR;
    end
  end

  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_SETUP))
    else $error("accepted request did not enter setup");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !s1_valid)
    else $error("result loaded while sweep writes still in flight");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (cnt_x < xhi && cnt_y < yhi && cnt_z < zhi))
    else $error("sweep counter outside its range");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!rsp_valid && !s2_valid))
    else $error("activity during clearing pass");

  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> ({1'b0, s2_addr} < (AW+1)'(DEPTH)))
    else $error("sweep write address beyond store");

endmodule

>>> src/vpf_dist.sv
module vpf_dist
  import vpf_pkg::*;
#(
  parameter int CW = 6
) (
  input  logic           clk,
  input  dist_cfg_t      cfg,
  input  logic [CW-1:0]  x,
  input  logic [CW-1:0]  y,
  input  logic [CW-1:0]  z,
  output logic           hit
);

  function automatic logic [MAG_W-1:0] abs_diff(input logic [CW-1:0] p,
                                                input logic signed [COORD_W-1:0] c);
    logic signed [DIFF_W-1:0] ps;
    logic signed [DIFF_W-1:0] cs;
    logic signed [DIFF_W-1:0] d;
    ps = signed'({{(DIFF_W-CW){1'b0}}, p});
    cs = {c[COORD_W-1], c};
    d  = ps - cs;
    if (d < 0) begin
      return MAG_W'(-d);
    end
    return MAG_W'(d);
  endfunction

  logic [MAG_W-1:0] mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [R2_W-1:0]  r2;
  logic [SUM_W-1:0] sum;
  logic [CMP_W-1:0] lhs;

  assign mag_x = abs_diff(x, cfg.x_c);
  assign mag_y = abs_diff(y, cfg.y_c);
  assign mag_z = abs_diff(z, cfg.z_c);

  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y <= SQ_W'(mag_y) * SQ_W'(mag_y);
    sq_z <= cfg.use_dz ? SQ_W'(mag_z) * SQ_W'(mag_z) : '0;
    r2   <= R2_W'(cfg.radius) * R2_W'(cfg.radius);
  end

  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign lhs = {sum, {FRAC_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    hit <= (lhs <= CMP_W'(r2));
  end

endmodule

>>> tb/vpf_checker.sv
module vpf_checker
  import vpf_pkg::*;
#(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_t                 rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DEPTH = MAX_X * MAX_Y * MAX_Z;

  logic [MAT_W-1:0]  grid [GRID_DEPTH];
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;
  rsp_t              awaited_results [$];
  int                mismatches = 0;

  function automatic int used_extent(input logic [SIZE_W-1:0] reg_val, input int limit);
    return (int'(reg_val) > limit) ? limit : int'(reg_val);
  endfunction

  function automatic int clamp_span(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint square_gap(input int a, input int b);
    longint d;
    d = a - b;
    return d * d;
  endfunction

  function automatic int voxel_index(input int x, input int y, input int z);
    return (x * MAX_Y + y) * MAX_Z + z;
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z,
                                 input int ex, input int ey, input int ez);
    return x >= 0 && x < ex && y >= 0 && y < ey && z >= 0 && z < ez;
  endfunction

  task automatic execute_voxel_command(input req_t r, output rsp_t res);
    int     ex, ey, ez;
    int     xa, xb, ya, yb, za, zb;
    int     x0, x1, y0, y1, z0, z1;
    longint r2;
    ex = used_extent(size_x, MAX_X);
    ey = used_extent(size_y, MAX_Y);
    ez = used_extent(size_z, MAX_Z);
    xa = $signed(r.x_a);
    xb = $signed(r.x_b);
    ya = $signed(r.y_a);
    yb = $signed(r.y_b);
    za = $signed(r.z_a);
    zb = $signed(r.z_b);
    r2 = longint'(r.radius) * longint'(r.radius);
    res.status = STATUS_DONE;
    res.read_material = MAT_CLEAR;
    case (r.command)
      CMD_SET: begin
        if (in_grid(xa, ya, za, ex, ey, ez)) grid[voxel_index(xa, ya, za)] = r.material;
        else res.status = STATUS_OOB;
      end
      CMD_UNIFORM: begin
        for (int x = 0; x < ex; x++)
          for (int y = 0; y < ey; y++)
            for (int z = 0; z < ez; z++)
              grid[voxel_index(x, y, z)] = r.material;
      end
      CMD_BOX: begin
        x0 = clamp_span(xa, ex);
        x1 = clamp_span(xb, ex);
        y0 = clamp_span(ya, ey);
        y1 = clamp_span(yb, ey);
        z0 = clamp_span(za, ez);
        z1 = clamp_span(zb, ez);
        for (int x = x0; x < x1; x++)
          for (int y = y0; y < y1; y++)
            for (int z = z0; z < z1; z++)
              grid[voxel_index(x, y, z)] = r.material;
      end
      CMD_SPHERE: begin
        for (int x = 0; x < ex; x++)
          for (int y = 0; y < ey; y++)
            for (int z = 0; z < ez; z++)
              if ((square_gap(x, xa) + square_gap(y, ya) + square_gap(z, za)) * 256 <= r2)
                grid[voxel_index(x, y, z)] = r.material;
      end
      CMD_CYLINDER: begin
        z0 = clamp_span(za, ez);
        z1 = clamp_span(zb, ez);
        for (int x = 0; x < ex; x++)
          for (int y = 0; y < ey; y++)
            if ((square_gap(x, xa) + square_gap(y, ya)) * 256 <= r2)
              for (int z = z0; z < z1; z++)
                grid[voxel_index(x, y, z)] = r.material;
      end
      CMD_READ: begin
        if (in_grid(xa, ya, za, ex, ey, ez)) res.read_material = grid[voxel_index(xa, ya, za)];
        else res.status = STATUS_OOB;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : observe
    rsp_t predicted;
    rsp_t oldest;
    if (rst) begin
      for (int i = 0; i < GRID_DEPTH; i++) grid[i] = MAT_CLEAR;
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      size_z = SIZE_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X: size_x = cfg_data;
          REG_SIZE_Y: size_y = cfg_data;
          REG_SIZE_Z: size_z = cfg_data;
          default: begin
          end
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, expected none, actual %0d/%0d",
                   $time, rsp.status, rsp.read_material);
        end else begin
          oldest = awaited_results.pop_front();
          if (rsp.status !== oldest.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest.status, rsp.status);
          end
          if (rsp.read_material !== oldest.read_material) begin
            mismatches++;
            $display("%0t: read_material mismatch, expected %0d, actual %0d",
                     $time, oldest.read_material, rsp.read_material);
          end
        end
      end
      if (req_valid && req_ready) begin
        execute_voxel_command(req, predicted);
        awaited_results.push_back(predicted);
      end
    end
    fail_count <= mismatches;
    outstanding <= awaited_results.size();
  end

endmodule

>>> tb/tb_top.sv
module tb_top
  import vpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_X          = 32;
  localparam int MAX_Y          = 32;
  localparam int MAX_Z          = 32;
  localparam int STALL_LIMIT    = 150000;
  localparam int TAIL_CYCLES    = 64;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 12;

  localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  int fail_count;
  int outstanding;
  int ext_x       = MAX_X;
  int ext_y       = MAX_Y;
  int ext_z       = MAX_Z;
  bit gap_free    = 1'b0;
  int rsp_hold    = 0;
  int quiet_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  voxel_primitive_fill #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  vpf_checker #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) voxel_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin : result_sink
    int draw;
    if (rst) begin
      rsp_hold <= 0;
      rsp_ready <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      draw = gap_free ? 0 : $urandom_range(0, 8);
      rsp_hold <= draw;
      rsp_ready <= (draw == 0);
    end else if (rsp_hold > 1) begin
      rsp_hold <= rsp_hold - 1;
    end else begin
      rsp_hold <= 0;
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic req_t make_request(input logic [CMD_W-1:0] code,
                                        input int xa, input int xb,
                                        input int ya, input int yb,
                                        input int za, input int zb,
                                        input int rad, input int mat);
    req_t r;
    r.command  = code;
    r.x_a      = xa[COORD_W-1:0];
    r.x_b      = xb[COORD_W-1:0];
    r.y_a      = ya[COORD_W-1:0];
    r.y_b      = yb[COORD_W-1:0];
    r.z_a      = za[COORD_W-1:0];
    r.z_b      = zb[COORD_W-1:0];
    r.radius   = rad[RADIUS_W-1:0];
    r.material = mat[MAT_W-1:0];
    return r;
  endfunction

  // Coordinates mostly land on or just around the grid in use so that fills and reads meet.
  function automatic int near_coord(input int span);
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, span + 2)) - 1;
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int pick_radius(input int span);
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 16 * (span + 2));
    return $urandom_range(0, 65535);
  endfunction

  function automatic req_t random_request();
    int                 roll;
    int                 span;
    logic [CMD_W-1:0]   code;
    roll = $urandom_range(0, 99);
    if (roll < 25) code = CMD_SET;
    else if (roll < 30) code = CMD_UNIFORM;
    else if (roll < 45) code = CMD_BOX;
    else if (roll < 55) code = CMD_SPHERE;
    else if (roll < 65) code = CMD_CYLINDER;
    else if (roll < 96) code = CMD_READ;
    else code = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
    span = ext_x;
    if (ext_y > span) span = ext_y;
    if (ext_z > span) span = ext_z;
    return make_request(code, near_coord(ext_x), near_coord(ext_x), near_coord(ext_y),
                        near_coord(ext_y), near_coord(ext_z), near_coord(ext_z),
                        pick_radius(span), $urandom_range(0, 255));
  endfunction

  task automatic send_request(input req_t item);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_data <= value[SIZE_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_extents(input int sx, input int sy, input int sz, input bit spare);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    if (spare) write_reg(REG_UNUSED, $urandom_range(0, 63));
    cfg_valid <= 1'b0;
    ext_x = (sx > MAX_X) ? MAX_X : sx;
    ext_y = (sy > MAX_Y) ? MAX_Y : sy;
    ext_z = (sz > MAX_Z) ? MAX_Z : sz;
  endtask

  initial begin : stimulus
    int big_axis;
    int dims [3];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The full grid after reset: corners, out-of-range coordinates and each kind of fill.
    send_request(make_request(CMD_SET, 31, 0, 31, 0, 31, 0, 0, 255));
    send_request(make_request(CMD_READ, 31, 0, 31, 0, 31, 0, 0, 0));
    send_request(make_request(CMD_SET, -2048, 2047, 2047, -2048, 0, 0, 65535, 90));
    send_request(make_request(CMD_READ, 0, 0, 0, 0, 32, 0, 0, 0));
    send_request(make_request(CMD_SET, 32, 0, 0, 0, 0, 0, 0, 1));
    send_request(make_request(CMD_UNIFORM, 0, 0, 0, 0, 0, 0, 0, 128));
    send_request(make_request(CMD_READ, 31, 0, 31, 0, 31, 0, 0, 0));
    send_request(make_request(CMD_BOX, -2048, 2047, 30, 2047, -2048, 2, 0, 7));
    send_request(make_request(CMD_BOX, 5, 5, 0, 32, 10, 3, 0, 9));
    send_request(make_request(CMD_READ, 31, 0, 31, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_SPHERE, -2048, 0, -2048, 0, -2048, 0, 65535, 34));
    send_request(make_request(CMD_CYLINDER, 16, 0, 16, 0, -5, 2047, 80, 51));
    send_request(make_request(CMD_READ, 16, 0, 16, 0, 10, 0, 0, 0));
    send_request(make_request(CMD_READ, 0, 0, 31, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_SPARE_7, -1, -1, -1, -1, -1, -1, 65535, 255));
    send_request(make_request(CMD_SPARE_6, 0, 0, 0, 0, 0, 0, 0, 0));

    // With every extent at zero nothing is in use.
    write_extents(0, 0, 0, 1'b0);
    send_request(make_request(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 66));
    send_request(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_UNIFORM, 0, 0, 0, 0, 0, 0, 0, 99));
    send_request(make_request(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 65535, 99));

    // An x extent above the grid saturates; a zero radius takes only the centre.
    write_extents(63, 1, 2, 1'b1);
    send_request(make_request(CMD_SPHERE, 3, 0, 0, 0, 1, 0, 0, 200));
    send_request(make_request(CMD_READ, 3, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(CMD_READ, 4, 0, 0, 0, 1, 0, 0, 0));
    send_request(make_request(CMD_CYLINDER, 31, 0, 0, 0, -1, 1, 16, 77));
    send_request(make_request(CMD_READ, 31, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(CMD_READ, 32, 0, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      big_axis = $urandom_range(0, 3);
      for (int a = 0; a < 3; a++) begin
        if (a == big_axis) dims[a] = $urandom_range(32, 63);
        else if ($urandom_range(0, 19) == 0) dims[a] = 0;
        else dims[a] = $urandom_range(1, 6);
      end
      write_extents(dims[0], dims[1], dims[2], $urandom_range(0, 3) == 0);
      gap_free = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(0, 9) == 0) drain_results();
        send_request(random_request());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
